/* hdl/json_string_unescape_macros.svh */
// assertion macros for the string unescape block
`ifndef JSON_STRING_UNESCAPE_MACROS_SVH
`define JSON_STRING_UNESCAPE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define JSU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define JSU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define JSU_ASSERT_IMP(label, ante, cons, msg)
`define JSU_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

/* hdl/jsu_pkg.sv */
package jsu_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int UNIT_W      = 16;
    localparam int OUT_LEN_W   = 16;

    localparam logic [UNIT_W-1:0] CTRL_LIMIT = 16'h0020;

    typedef enum logic [2:0] {
        ST_CHAR    = 3'd0,
        ST_END     = 3'd1,
        ST_UNTERM  = 3'd2,
        ST_CTRL    = 3'd3,
        ST_BADHEX  = 3'd4,
        ST_BADESC  = 3'd5,
        ST_NOQUOTE = 3'd6
    } t_status;

    typedef struct packed {
        logic [UNIT_W-1:0]    unit;
        t_status              status;
        logic [OUT_LEN_W-1:0] length;
    } t_result;

    // count clipped to the reported length width
    function automatic logic [OUT_LEN_W-1:0] sat_length(input logic [LENGTH_BITS-1:0] count);
        logic [LENGTH_BITS+OUT_LEN_W-1:0] ext;
        logic [LENGTH_BITS+OUT_LEN_W-1:0] lim;
        ext = {{OUT_LEN_W{1'b0}}, count};
        lim = {{LENGTH_BITS{1'b0}}, {OUT_LEN_W{1'b1}}};
        if (ext > lim) begin
            sat_length = {OUT_LEN_W{1'b1}};
        end else begin
            sat_length = ext[OUT_LEN_W-1:0];
        end
    endfunction

endpackage

/* hdl/json_string_unescape.sv */
// throughput: one source beat per cycle while the result register is free (i_out_stall
// low or register empty), set by the input register feeding one step of decode logic into
// the result register; a source beat that gives no result still takes a decode step
// reset: synchronous active-low i_rst_n clears the decode state to idle and empties both
// registers
`include "json_string_unescape_macros.svh"

module json_string_unescape
    import jsu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [UNIT_W-1:0]    i_code_unit,
    input  logic                 i_end_of_source,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [UNIT_W-1:0]    o_out_unit,
    output logic [2:0]           o_status,
    output logic [OUT_LEN_W-1:0] o_string_length
);

    logic              r_in_valid;
    logic [UNIT_W-1:0] r_code_unit;
    logic              r_end_of_source;

    logic    w_go;
    logic    w_out_free;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out_res;
    logic    w_accept;

    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_go       = r_in_valid && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_code_unit     <= i_code_unit;
            r_end_of_source <= i_end_of_source;
        end
    end

    jsu_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_go            (w_go),
        .i_code_unit     (r_code_unit),
        .i_end_of_source (r_end_of_source),
        .o_res_valid     (w_res_valid),
        .o_res           (w_res)
    );

    jsu_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_go && w_res_valid),
        .i_res       (w_res),
        .i_out_stall (i_out_stall),
        .o_free      (w_out_free),
        .o_valid     (o_out_valid),
        .o_res       (w_out_res)
    );

    assign o_out_unit      = w_out_res.unit;
    assign o_status        = w_out_res.status;
    assign o_string_length = w_out_res.length;

    `JSU_ASSERT_IMP(a_err_unit_zero, o_out_valid && o_status != ST_CHAR, o_out_unit == '0, "non-char beat carries a unit")
    `JSU_ASSERT_IMP(a_len_only_end, o_out_valid && o_status != ST_END, o_string_length == '0, "length outside end beat")
    `JSU_ASSERT_IMP(a_stall_cause, o_in_stall, o_out_valid && i_out_stall, "input stalled with free result register")
    `JSU_ASSERT_NXT(a_silent_step, w_go && !w_res_valid && !(o_out_valid && i_out_stall), !o_out_valid, "result beat without cause")

endmodule

/* hdl/jsu_core.sv */
module jsu_core
    import jsu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [UNIT_W-1:0] i_code_unit,
    input  logic              i_end_of_source,
    output logic              o_res_valid,
    output t_result           o_res
);

    typedef enum logic [1:0] {
        M_IDLE = 2'd0,
        M_STR  = 2'd1,
        M_ESC  = 2'd2,
        M_HEX  = 2'd3
    } t_mode;

    localparam logic [UNIT_W-1:0] CH_QUOTE  = 16'h0022;
    localparam logic [UNIT_W-1:0] CH_BSLASH = 16'h005C;
    localparam logic [UNIT_W-1:0] CH_SLASH  = 16'h002F;
    localparam logic [UNIT_W-1:0] CH_B      = 16'h0062;
    localparam logic [UNIT_W-1:0] CH_F      = 16'h0066;
    localparam logic [UNIT_W-1:0] CH_N      = 16'h006E;
    localparam logic [UNIT_W-1:0] CH_R      = 16'h0072;
    localparam logic [UNIT_W-1:0] CH_T      = 16'h0074;
    localparam logic [UNIT_W-1:0] CH_U      = 16'h0075;
    localparam logic [UNIT_W-1:0] CH_BS     = 16'h0008;
    localparam logic [UNIT_W-1:0] CH_FF     = 16'h000C;
    localparam logic [UNIT_W-1:0] CH_LF     = 16'h000A;
    localparam logic [UNIT_W-1:0] CH_CR     = 16'h000D;
    localparam logic [UNIT_W-1:0] CH_TAB    = 16'h0009;
    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

    t_mode                  r_mode, n_mode;
    logic [1:0]             r_hex_cnt, n_hex_cnt;
    logic [UNIT_W-1:0]      r_hex_acc, n_hex_acc;
    logic [LENGTH_BITS-1:0] r_count, n_count;

    logic              w_fail;
    t_status           w_fail_status;
    logic              w_put;
    logic [UNIT_W-1:0] w_put_unit;
    logic              w_end;
    logic              w_hex_ok;
    logic [3:0]        w_hex_val;
    logic [UNIT_W-1:0] w_acc_next;

    // ascii hex digit decode
    always_comb begin
        w_hex_ok  = 1'b1;
        w_hex_val = 4'd0;
        if (i_code_unit inside {[16'h0030:16'h0039]}) begin
            w_hex_val = 4'(i_code_unit - 16'h0030);
        end else if (i_code_unit inside {[16'h0061:16'h0066]}) begin
            w_hex_val = 4'(i_code_unit - 16'h0057);
        end else if (i_code_unit inside {[16'h0041:16'h0046]}) begin
            w_hex_val = 4'(i_code_unit - 16'h0037);
        end else begin
            w_hex_ok = 1'b0;
        end
    end

    assign w_acc_next = {r_hex_acc[UNIT_W-5:0], w_hex_val};

    always_comb begin
        n_mode        = r_mode;
        n_hex_cnt     = r_hex_cnt;
        n_hex_acc     = r_hex_acc;
        n_count       = r_count;
        w_fail        = 1'b0;
        w_fail_status = ST_NOQUOTE;
        w_put         = 1'b0;
        w_put_unit    = i_code_unit;
        w_end         = 1'b0;
        case (r_mode)
            M_IDLE: begin
                if (!i_end_of_source && i_code_unit == CH_QUOTE) begin
                    n_mode    = M_STR;
                    n_count   = '0;
                    n_hex_cnt = 2'd0;
                    n_hex_acc = '0;
                end else begin
                    w_fail        = 1'b1;
                    w_fail_status = ST_NOQUOTE;
                end
            end
            M_STR: begin
                if (i_end_of_source) begin
                    w_fail        = 1'b1;
                    w_fail_status = ST_UNTERM;
                end else if (i_code_unit == CH_QUOTE) begin
                    w_end  = 1'b1;
                    n_mode = M_IDLE;
                end else if (i_code_unit < CTRL_LIMIT) begin
                    w_fail        = 1'b1;
                    w_fail_status = ST_CTRL;
                end else if (i_code_unit == CH_BSLASH) begin
                    n_mode = M_ESC;
                end else begin
                    w_put = 1'b1;
                end
            end
            M_ESC: begin
                if (i_end_of_source) begin
                    w_fail        = 1'b1;
                    w_fail_status = ST_BADESC;
                end else begin
                    n_mode = M_STR;
                    case (i_code_unit)
                        CH_B: begin
                            w_put      = 1'b1;
                            w_put_unit = CH_BS;
                        end
                        CH_F: begin
                            w_put      = 1'b1;
                            w_put_unit = CH_FF;
                        end
                        CH_N: begin
                            w_put      = 1'b1;
                            w_put_unit = CH_LF;
                        end
                        CH_R: begin
                            w_put      = 1'b1;
                            w_put_unit = CH_CR;
                        end
                        CH_T: begin
                            w_put      = 1'b1;
                            w_put_unit = CH_TAB;
                        end
                        CH_QUOTE, CH_BSLASH, CH_SLASH: begin
                            w_put = 1'b1;
                        end
                        CH_U: begin
                            n_mode    = M_HEX;
                            n_hex_cnt = 2'd0;
                            n_hex_acc = '0;
                        end
                        default: begin
                            w_fail        = 1'b1;
                            w_fail_status = ST_BADESC;
                        end
                    endcase
                end
            end
            M_HEX: begin
                if (i_end_of_source || !w_hex_ok) begin
                    w_fail        = 1'b1;
                    w_fail_status = ST_BADHEX;
                end else if (r_hex_cnt == 2'd3) begin
                    w_put      = 1'b1;
                    w_put_unit = w_acc_next;
                    n_mode     = M_STR;
                    n_hex_cnt  = 2'd0;
                    n_hex_acc  = '0;
                end else begin
                    n_hex_cnt = r_hex_cnt + 2'd1;
                    n_hex_acc = w_acc_next;
                end
            end
            default: begin
                n_mode = M_IDLE;
            end
        endcase

        if (w_fail) begin
            n_mode    = M_IDLE;
            n_hex_cnt = 2'd0;
            n_hex_acc = '0;
        end
        if (w_put && r_count != COUNT_MAX) begin
            n_count = r_count + 1'b1;
        end
    end

    always_comb begin
        o_res_valid = w_fail || w_put || w_end;
        o_res       = '{unit: '0, status: ST_CHAR, length: '0};
        if (w_fail) begin
            o_res.status = w_fail_status;
        end else if (w_end) begin
            o_res.status = ST_END;
            o_res.length = sat_length(r_count);
        end else begin
            o_res.unit = w_put_unit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_IDLE;
            r_hex_cnt <= 2'd0;
            r_hex_acc <= '0;
            r_count   <= '0;
        end else if (i_go) begin
            r_mode    <= n_mode;
            r_hex_cnt <= n_hex_cnt;
            r_hex_acc <= n_hex_acc;
            r_count   <= n_count;
        end
    end

endmodule

/* hdl/jsu_out_reg.sv */
module jsu_out_reg
    import jsu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_out_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || !i_out_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

/* test/json_string_unescape_tb.sv */
module json_string_unescape_tb;
    import jsu_pkg::*;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              eos;
    } t_source_beat;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_STRING,
        SCAN_ESCAPE,
        SCAN_HEX
    } t_scan_mode;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    localparam logic [UNIT_W-1:0] CH_QUOTE     = 16'h0022;
    localparam logic [UNIT_W-1:0] CH_BACKSLASH = 16'h005C;
    localparam logic [UNIT_W-1:0] CH_SLASH     = 16'h002F;
    localparam logic [UNIT_W-1:0] CH_LOWER_B   = 16'h0062;
    localparam logic [UNIT_W-1:0] CH_LOWER_F   = 16'h0066;
    localparam logic [UNIT_W-1:0] CH_LOWER_N   = 16'h006E;
    localparam logic [UNIT_W-1:0] CH_LOWER_R   = 16'h0072;
    localparam logic [UNIT_W-1:0] CH_LOWER_T   = 16'h0074;
    localparam logic [UNIT_W-1:0] CH_LOWER_U   = 16'h0075;
    localparam logic [UNIT_W-1:0] CH_LOWER_A   = 16'h0061;
    localparam logic [UNIT_W-1:0] CH_UPPER_A   = 16'h0041;
    localparam logic [UNIT_W-1:0] CH_UPPER_F   = 16'h0046;
    localparam logic [UNIT_W-1:0] CH_0         = 16'h0030;
    localparam logic [UNIT_W-1:0] CH_9         = 16'h0039;
    localparam logic [UNIT_W-1:0] UNIT_BS      = 16'h0008;
    localparam logic [UNIT_W-1:0] UNIT_FF      = 16'h000C;
    localparam logic [UNIT_W-1:0] UNIT_LF      = 16'h000A;
    localparam logic [UNIT_W-1:0] UNIT_CR      = 16'h000D;
    localparam logic [UNIT_W-1:0] UNIT_TAB     = 16'h0009;
    localparam logic [OUT_LEN_W-1:0] MAX_LEN   = '1;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [UNIT_W-1:0]    i_code_unit = '0;
    logic                 i_end_of_source = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [UNIT_W-1:0]    o_out_unit;
    logic [2:0]           o_status;
    logic [OUT_LEN_W-1:0] o_string_length;

    t_source_beat source_q[$];
    t_result      decoded_q[$];

    t_scan_mode             scan_mode = SCAN_IDLE;
    logic [1:0]             hex_count = '0;
    logic [UNIT_W-1:0]      hex_word = '0;
    logic [LENGTH_BITS-1:0] decoded_count = '0;

    int          mismatch_count = 0;
    int          beats_accepted = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    logic        hold_off = 1'b0;
    t_stall_mode stall_mode = STALL_NONE;
    logic [5:0]  stall_phase = '0;

    json_string_unescape dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_code_unit     (i_code_unit),
        .i_end_of_source (i_end_of_source),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_unit      (o_out_unit),
        .o_status        (o_status),
        .o_string_length (o_string_length)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic int hex_nibble(input logic [UNIT_W-1:0] c);
        if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
        if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
        if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
        return -1;
    endfunction

    function automatic logic [UNIT_W-1:0] escape_letter(input int k);
        case (k)
            0: return CH_LOWER_B;
            1: return CH_LOWER_F;
            2: return CH_LOWER_N;
            3: return CH_LOWER_R;
            4: return CH_LOWER_T;
            5: return CH_QUOTE;
            6: return CH_BACKSLASH;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic logic [UNIT_W-1:0] hex_char(input int v);
        if (v < 10) return CH_0 + UNIT_W'(v);
        return (($urandom_range(0, 1) == 0) ? CH_LOWER_A : CH_UPPER_A) + UNIT_W'(v - 10);
    endfunction

    // any unit that stays literal inside a string
    function automatic logic [UNIT_W-1:0] plain_unit();
        logic [UNIT_W-1:0] c;
        do begin
            c = ($urandom_range(0, 3) == 0) ? UNIT_W'($urandom_range(16'h20, 16'h7E))
                                            : UNIT_W'($urandom_range(16'h20, 16'hFFFF));
        end while (c == CH_QUOTE || c == CH_BACKSLASH);
        return c;
    endfunction

    function automatic logic [UNIT_W-1:0] bad_escape();
        logic [UNIT_W-1:0] c;
        logic              known;
        do begin
            c = ($urandom_range(0, 1) == 0) ? UNIT_W'($urandom_range(0, 127))
                                            : UNIT_W'($urandom_range(0, 16'hFFFF));
            known = (c == CH_LOWER_U);
            for (int k = 0; k < 8; k++) known |= (c == escape_letter(k));
        end while (known);
        return c;
    endfunction

    function automatic logic [UNIT_W-1:0] bad_hex();
        logic [UNIT_W-1:0] c;
        do begin
            c = ($urandom_range(0, 1) == 0) ? UNIT_W'($urandom_range(0, 127))
                                            : UNIT_W'($urandom_range(0, 16'hFFFF));
        end while (hex_nibble(c) >= 0);
        return c;
    endfunction

    task automatic push_unit(input logic [UNIT_W-1:0] c);
        source_q.push_back('{code_unit: c, eos: 1'b0});
    endtask

    // payload is don't-care on an end of source, so keep it random
    task automatic push_eos();
        source_q.push_back('{code_unit: UNIT_W'($urandom_range(0, 16'hFFFF)), eos: 1'b1});
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_unit({8'h00, s[i]});
    endtask

    task automatic push_random_string();
        int len;
        int k;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 16);
        k = $urandom_range(0, 3);
        push_unit(CH_QUOTE);
        repeat (len) begin
            case ($urandom_range(0, 9))
                6, 7: begin
                    push_unit(CH_BACKSLASH);
                    push_unit(escape_letter($urandom_range(0, 7)));
                end
                8, 9: begin
                    push_unit(CH_BACKSLASH);
                    push_unit(CH_LOWER_U);
                    repeat (4) push_unit(hex_char($urandom_range(0, 15)));
                end
                default: push_unit(plain_unit());
            endcase
        end
        if ($urandom_range(0, 5) != 0) begin
            push_unit(CH_QUOTE);
        end else begin
            case ($urandom_range(0, 5))
                0: push_eos();
                1: push_unit(UNIT_W'($urandom_range(0, CTRL_LIMIT - 1)));
                2: begin
                    push_unit(CH_BACKSLASH);
                    push_unit(bad_escape());
                end
                3: begin
                    push_unit(CH_BACKSLASH);
                    push_eos();
                end
                4: begin
                    push_unit(CH_BACKSLASH);
                    push_unit(CH_LOWER_U);
                    repeat (k) push_unit(hex_char($urandom_range(0, 15)));
                    push_unit(bad_hex());
                end
                default: begin
                    push_unit(CH_BACKSLASH);
                    push_unit(CH_LOWER_U);
                    repeat (k) push_unit(hex_char($urandom_range(0, 15)));
                    push_eos();
                end
            endcase
        end
    endtask

    task automatic push_result(input logic [UNIT_W-1:0] u, input t_status s,
                               input logic [OUT_LEN_W-1:0] len);
        t_result r;
        r.unit = u;
        r.status = s;
        r.length = len;
        decoded_q.push_back(r);
    endtask

    task automatic abort_string(input t_status s);
        scan_mode = SCAN_IDLE;
        hex_count = '0;
        hex_word = '0;
        push_result('0, s, '0);
    endtask

    task automatic emit_unit(input logic [UNIT_W-1:0] u);
        if (decoded_count != '1) decoded_count++;
        push_result(u, ST_CHAR, '0);
    endtask

    task automatic decode_source_unit(input logic [UNIT_W-1:0] cu, input logic eos);
        int nib;
        nib = hex_nibble(cu);
        case (scan_mode)
            SCAN_IDLE: begin
                if (!eos && cu == CH_QUOTE) begin
                    scan_mode = SCAN_STRING;
                    decoded_count = '0;
                    hex_count = '0;
                    hex_word = '0;
                end else begin
                    abort_string(ST_NOQUOTE);
                end
            end
            SCAN_STRING: begin
                if (eos) begin
                    abort_string(ST_UNTERM);
                end else if (cu == CH_QUOTE) begin
                    scan_mode = SCAN_IDLE;
                    push_result('0, ST_END, (decoded_count > MAX_LEN) ? MAX_LEN
                                                                      : OUT_LEN_W'(decoded_count));
                end else if (cu < CTRL_LIMIT) begin
                    abort_string(ST_CTRL);
                end else if (cu == CH_BACKSLASH) begin
                    scan_mode = SCAN_ESCAPE;
                end else begin
                    emit_unit(cu);
                end
            end
            SCAN_ESCAPE: begin
                if (eos) begin
                    abort_string(ST_BADESC);
                end else begin
                    scan_mode = SCAN_STRING;
                    case (cu)
                        CH_LOWER_B:   emit_unit(UNIT_BS);
                        CH_LOWER_F:   emit_unit(UNIT_FF);
                        CH_LOWER_N:   emit_unit(UNIT_LF);
                        CH_LOWER_R:   emit_unit(UNIT_CR);
                        CH_LOWER_T:   emit_unit(UNIT_TAB);
                        CH_QUOTE:     emit_unit(CH_QUOTE);
                        CH_BACKSLASH: emit_unit(CH_BACKSLASH);
                        CH_SLASH:     emit_unit(CH_SLASH);
                        CH_LOWER_U: begin
                            scan_mode = SCAN_HEX;
                            hex_count = '0;
                            hex_word = '0;
                        end
                        default: abort_string(ST_BADESC);
                    endcase
                end
            end
            default: begin
                if (eos || nib < 0) begin
                    abort_string(ST_BADHEX);
                end else begin
                    hex_word = {hex_word[UNIT_W-5:0], 4'(nib)};
                    if (hex_count == 2'd3) begin
                        emit_unit(hex_word);
                        scan_mode = SCAN_STRING;
                        hex_count = '0;
                        hex_word = '0;
                    end else begin
                        hex_count++;
                    end
                end
            end
        endcase
    endtask

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("mismatch: %s", msg);
    endtask

    always @(posedge i_clk) begin : source_driver
        t_source_beat beat;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            beat = source_q.pop_front();
            decode_source_unit(beat.code_unit, beat.eos);
            beats_accepted++;
        end
        if (i_rst_n && !(i_in_valid && o_in_stall)) begin
            if (gap_left != 0 || source_q.size() == 0) begin
                if (gap_left != 0) gap_left--;
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                i_code_unit <= source_q[0].code_unit;
                i_end_of_source <= source_q[0].eos;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_result want;
        logic    stall_next;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (decoded_q.size() == 0) begin
                note_mismatch($sformatf("unexpected beat unit %h status %0d length %0d",
                                        o_out_unit, o_status, o_string_length));
            end else begin
                want = decoded_q.pop_front();
                if (o_out_unit !== want.unit || o_status !== want.status
                        || o_string_length !== want.length) begin
                    note_mismatch($sformatf(
                        "expected unit %h status %0d length %0d, got unit %h status %0d length %0d",
                        want.unit, want.status, want.length,
                        o_out_unit, o_status, o_string_length));
                end
            end
        end
        stall_phase++;
        if (stall_phase == '0) stall_mode = t_stall_mode'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:   stall_next = 1'b0;
            STALL_LIGHT:  stall_next = ($urandom_range(0, 3) == 0);
            STALL_HEAVY:  stall_next = ($urandom_range(0, 3) != 0);
            default:      stall_next = stall_phase[0];
        endcase
        i_out_stall <= hold_off || stall_next;
    end

    // long hold-off on the result side so the block backs up into its input
    initial begin
        while (beats_accepted < 1000) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : stimulus
        int n;
        push_eos();
        push_text("\"\\b\\f\\n\\r\\t\\\"\\\\\\/");
        push_unit(16'h0020);
        push_unit(16'hFFFF);
        push_text("\\uFf09\"");
        push_text("\"\"");
        push_text("\"");
        push_eos();
        push_text("\"");
        push_unit(16'h001F);
        push_text("\"\\");
        push_eos();
        push_text("\"\\u1G");
        push_text("\"\\u");
        push_eos();

        // one long string
        push_unit(CH_QUOTE);
        repeat (300) push_unit(plain_unit());
        push_unit(CH_QUOTE);

        n = source_q.size();
        while (source_q.size() - n < 1700) begin
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 5) == 0) push_eos();
                    else push_unit(UNIT_W'($urandom_range(0, 16'hFFFF)));
                end
            end else begin
                push_random_string();
            end
        end

        while (source_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && decoded_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/jsu_pkg.sv
hdl/jsu_core.sv
hdl/jsu_out_reg.sv
hdl/json_string_unescape.sv
test/json_string_unescape_tb.sv
